@@ hdl/tls_pkg.sv @@
package tls_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned PosW  = 6;
  localparam int unsigned LenW  = 7;
  localparam int unsigned CfgAddrW = 2;

  localparam logic [CfgAddrW-1:0] CfgDiag    = 2'd0;
  localparam logic [CfgAddrW-1:0] CfgOffdiag = 2'd1;
  localparam logic [CfgAddrW-1:0] CfgLength  = 2'd2;

  localparam logic signed [65:0] SatMax = 66'sd2147483647;
  localparam logic signed [65:0] SatMin = -66'sd2147483648;

  typedef struct packed {
    logic                    sat;
    logic signed [DataW-1:0] val;
  } sat_t;

  typedef struct packed {
    logic done;
    sat_t q;
  } div_res_t;

  typedef struct packed {
    logic             re;
    logic [PosW-1:0]  raddr;
    logic             we_upper;
    logic             we_rhs;
    logic [PosW-1:0]  waddr;
    logic [DataW-1:0] wdata_upper;
    logic [DataW-1:0] wdata_rhs;
  } mem_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_C,
    S_MUL_D,
    S_SUB_D,
    S_DIV_START,
    S_DIV_WAIT,
    S_BK_RD,
    S_BK_MUL,
    S_BK_SUB,
    S_EM_RD,
    S_EM_LOAD,
    S_EM_HOLD
  } state_e;

  function automatic sat_t sat32(input logic signed [65:0] v);
    sat_t r;
    if (v > SatMax) begin
      r.sat = 1'b1;
      r.val = 32'sh7fffffff;
    end else if (v < SatMin) begin
      r.sat = 1'b1;
      r.val = 32'sh80000000;
    end else begin
      r.sat = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ hdl/tridiagonal_line_solver.sv @@
// Channel  Direction  Handshake                 Payload
// input    in         in_valid_i / in_stall_o   rhs_value_i
// output   out        out_valid_o / out_stall_i solution_value_o, position_o,
//                                               last_out_o, overflow_o
// config   in         cfg_we_i                  cfg_addr_i, cfg_wdata_i
//
// After an input transfer the input stalls while the block reads the store, runs the
// multiplies and subtract (skipped at position zero) and the bit-serial dividers
// (32 + FRAC_BITS steps).
// The closing element adds a back substitution pass (read, multiply, subtract per step)
// and a read, load and hold per result transfer, each step bound by the store reads.
// Reset sets control state and config only; data registers and stores need no clearing.
// A stalled result holds the whole block.
module tridiagonal_line_solver #(
  parameter int unsigned MAX_LEN   = 64,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_addr_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] rhs_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] solution_value_o,
  output logic [5:0]         position_o,
  output logic               last_out_o,
  output logic               overflow_o
);

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam logic [31:0] DiagOne = 32'd1 << FRAC_BITS;

  tls_pkg::state_e state_q, state_d;

  logic signed [31:0] diag_q;
  logic signed [31:0] offdiag_q;
  logic [6:0]         length_q;
  logic [6:0]         count_q;
  logic               flag_q;

  logic [AW-1:0]      idx_q;
  logic               last_q;
  logic [AW-1:0]      i_q;
  logic [AW-1:0]      e_q;
  logic signed [31:0] denom_q;
  logic signed [31:0] num_q;
  logic signed [31:0] prev_d_q;
  logic signed [31:0] x_q;
  logic signed [31:0] sol_q;
  logic               out_valid_q;

  logic [6:0]         eff_len;
  logic [6:0]         len_m1;
  logic [6:0]         idx_new;
  logic               accept;

  tls_pkg::mem_req_t  mem_req;
  logic [31:0]        rd_upper;
  logic [31:0]        rd_rhs;
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  tls_pkg::sat_t      mul_res;
  logic               div_start;
  tls_pkg::div_res_t  div_c;
  tls_pkg::div_res_t  div_d;
  tls_pkg::sat_t      diff_sat;
  logic signed [31:0] diff_lhs;
  logic signed [32:0] diff;

  always_comb begin
    if (length_q < 7'd2) begin
      eff_len = 7'd2;
    end else if (length_q > 7'(MAX_LEN)) begin
      eff_len = 7'(MAX_LEN);
    end else begin
      eff_len = length_q;
    end
    len_m1  = eff_len - 7'd1;
    idx_new = (count_q < len_m1) ? count_q : len_m1;
  end

  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    case (state_q)
      tls_pkg::S_MUL_D: diff_lhs = diag_q;
      tls_pkg::S_SUB_D: diff_lhs = num_q;
      default:          diff_lhs = prev_d_q;
    endcase
    diff     = 33'(diff_lhs) - 33'(mul_res.val);
    diff_sat = tls_pkg::sat32(66'(diff));
  end

  tls_store #(
    .MAX_LEN(MAX_LEN)
  ) u_store (
    .clk_i      (clk_i),
    .req_i      (mem_req),
    .rd_upper_o (rd_upper),
    .rd_rhs_o   (rd_rhs)
  );

  tls_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .res_o (mul_res)
  );

  tls_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div_upper (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (offdiag_q),
    .den_i   (denom_q),
    .res_o   (div_c)
  );

  tls_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div_rhs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (denom_q),
    .res_o   (div_d)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      tls_pkg::S_IDLE: begin
        if (accept) begin
          state_d = (idx_new == 7'd0) ? tls_pkg::S_DIV_START : tls_pkg::S_MUL_C;
        end
      end
      tls_pkg::S_MUL_C:     state_d = tls_pkg::S_MUL_D;
      tls_pkg::S_MUL_D:     state_d = tls_pkg::S_SUB_D;
      tls_pkg::S_SUB_D:     state_d = tls_pkg::S_DIV_START;
      tls_pkg::S_DIV_START: state_d = tls_pkg::S_DIV_WAIT;
      tls_pkg::S_DIV_WAIT: begin
        if (div_d.done) begin
          state_d = last_q ? tls_pkg::S_BK_RD : tls_pkg::S_IDLE;
        end
      end
      tls_pkg::S_BK_RD:  state_d = tls_pkg::S_BK_MUL;
      tls_pkg::S_BK_MUL: state_d = tls_pkg::S_BK_SUB;
      tls_pkg::S_BK_SUB: begin
        state_d = (i_q == AW'(1)) ? tls_pkg::S_EM_RD : tls_pkg::S_BK_RD;
      end
      tls_pkg::S_EM_RD:   state_d = tls_pkg::S_EM_LOAD;
      tls_pkg::S_EM_LOAD: state_d = tls_pkg::S_EM_HOLD;
      tls_pkg::S_EM_HOLD: begin
        if (!out_stall_i) begin
          state_d = (e_q == '0) ? tls_pkg::S_IDLE : tls_pkg::S_EM_RD;
        end
      end
      default: state_d = tls_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    mem_req     = '0;
    mul_a       = offdiag_q;
    mul_b       = prev_d_q;
    div_start   = 1'b0;
    in_stall_o  = state_q != tls_pkg::S_IDLE;
    case (state_q)
      tls_pkg::S_IDLE: begin
        mem_req.re    = in_valid_i;
        mem_req.raddr = 6'(idx_new - 7'd1);
      end
      tls_pkg::S_MUL_C: begin
        mul_b = rd_upper;
      end
      tls_pkg::S_DIV_START: begin
        div_start = 1'b1;
      end
      tls_pkg::S_DIV_WAIT: begin
        mem_req.waddr       = 6'(idx_q);
        mem_req.we_upper    = div_d.done && !last_q;
        mem_req.we_rhs      = div_d.done;
        mem_req.wdata_upper = div_c.q.val;
        mem_req.wdata_rhs   = div_d.q.val;
      end
      tls_pkg::S_BK_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = 6'(i_q - AW'(1));
      end
      tls_pkg::S_BK_MUL: begin
        mul_a = rd_upper;
        mul_b = x_q;
      end
      tls_pkg::S_BK_SUB: begin
        mem_req.we_rhs    = 1'b1;
        mem_req.waddr     = 6'(i_q - AW'(1));
        mem_req.wdata_rhs = diff_sat.val;
      end
      tls_pkg::S_EM_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = 6'(e_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tls_pkg::S_IDLE;
      diag_q      <= DiagOne;
      offdiag_q   <= '0;
      length_q    <= 7'd64;
      count_q     <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          tls_pkg::CfgDiag:    diag_q    <= cfg_wdata_i;
          tls_pkg::CfgOffdiag: offdiag_q <= cfg_wdata_i;
          tls_pkg::CfgLength:  length_q  <= cfg_wdata_i[6:0];
          default: begin
          end
        endcase
      end
      case (state_q)
        tls_pkg::S_MUL_D: flag_q <= flag_q | mul_res.sat | diff_sat.sat;
        tls_pkg::S_SUB_D: flag_q <= flag_q | mul_res.sat | diff_sat.sat;
        tls_pkg::S_DIV_WAIT: begin
          if (div_d.done) begin
            flag_q <= flag_q | div_d.q.sat | (!last_q & div_c.q.sat);
            if (!last_q) begin
              count_q <= 7'(idx_q) + 7'd1;
            end
          end
        end
        tls_pkg::S_BK_SUB:  flag_q <= flag_q | mul_res.sat | diff_sat.sat;
        tls_pkg::S_EM_LOAD: out_valid_q <= 1'b1;
        tls_pkg::S_EM_HOLD: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            if (e_q == '0) begin
              count_q <= '0;
              flag_q  <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      tls_pkg::S_IDLE: begin
        if (accept) begin
          idx_q   <= idx_new[AW-1:0];
          last_q  <= count_q >= len_m1;
          denom_q <= diag_q;
          num_q   <= rhs_value_i;
        end
      end
      tls_pkg::S_MUL_C: prev_d_q <= rd_rhs;
      tls_pkg::S_MUL_D: denom_q  <= diff_sat.val;
      tls_pkg::S_SUB_D: num_q    <= diff_sat.val;
      tls_pkg::S_DIV_WAIT: begin
        x_q <= div_d.q.val;
        i_q <= idx_q;
        e_q <= idx_q;
      end
      tls_pkg::S_BK_MUL: prev_d_q <= rd_rhs;
      tls_pkg::S_BK_SUB: begin
        x_q <= diff_sat.val;
        i_q <= i_q - AW'(1);
      end
      tls_pkg::S_EM_LOAD: sol_q <= rd_rhs;
      tls_pkg::S_EM_HOLD: begin
        if (!out_stall_i && e_q != '0) begin
          e_q <= e_q - AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign solution_value_o = sol_q;
  assign position_o       = 6'(e_q);
  assign last_out_o       = e_q == '0;
  assign overflow_o       = flag_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> state_q == tls_pkg::S_EM_HOLD)
    else $error("result shown outside the transfer state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o)
    else $error("input taken while a result is pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q < 7'(MAX_LEN))
    else $error("element count beyond the line");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_out_o) |=> $past(position_o) == position_o + 6'd1)
    else $error("positions not emitted in descending order");

endmodule

@@ hdl/tls_store.sv @@
module tls_store #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic                clk_i,
  input  tls_pkg::mem_req_t   req_i,
  output logic [31:0]         rd_upper_o,
  output logic [31:0]         rd_rhs_o
);

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic [31:0] upper_mem [MAX_LEN];
  logic [31:0] rhs_mem   [MAX_LEN];

  always_ff @(posedge clk_i) begin
    if (req_i.we_upper) begin
      upper_mem[req_i.waddr[AW-1:0]] <= req_i.wdata_upper;
    end
    if (req_i.re) begin
      rd_upper_o <= upper_mem[req_i.raddr[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we_rhs) begin
      rhs_mem[req_i.waddr[AW-1:0]] <= req_i.wdata_rhs;
    end
    if (req_i.re) begin
      rd_rhs_o <= rhs_mem[req_i.raddr[AW-1:0]];
    end
  end

endmodule

@@ hdl/tls_mul.sv @@
module tls_mul #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output tls_pkg::sat_t      res_o
);

  logic signed [63:0] prod_q;
  logic [63:0]        mag;
  logic [63:0]        shifted;
  logic signed [65:0] wide;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  always_comb begin
    mag     = prod_q[63] ? (64'd0 - prod_q) : prod_q;
    shifted = mag >> FRAC_BITS;
    wide    = 66'(shifted);
    if (prod_q[63]) begin
      wide = -wide;
    end
    res_o = tls_pkg::sat32(wide);
  end

endmodule

@@ hdl/tls_div.sv @@
module tls_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [31:0]  num_i,
  input  logic signed [31:0]  den_i,
  output tls_pkg::div_res_t   res_o
);

  localparam int unsigned NW = 32 + FRAC_BITS;
  localparam int unsigned CW = $clog2(NW + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [31:0]   rem_q;
  logic [NW-1:0] quo_q;
  logic [31:0]   dmag_q;
  logic          neg_q;
  logic          zero_q;
  logic          npos_q;
  logic          nneg_q;
  logic [32:0]   trial;
  logic          fits;
  logic [31:0]   nmag;
  logic [31:0]   dmag;
  logic signed [65:0] wide;

  assign nmag  = num_i[31] ? (32'd0 - num_i) : num_i;
  assign dmag  = den_i[31] ? (32'd0 - den_i) : den_i;
  assign trial = {rem_q, quo_q[NW-1]};
  assign fits  = trial >= {1'b0, dmag_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quo_q  <= {nmag, {FRAC_BITS{1'b0}}};
      dmag_q <= dmag;
      neg_q  <= num_i[31] ^ den_i[31];
      zero_q <= den_i == 32'sd0;
      npos_q <= num_i > 32'sd0;
      nneg_q <= num_i[31];
    end else if (busy_q) begin
      rem_q <= fits ? 32'(trial - {1'b0, dmag_q}) : trial[31:0];
      quo_q <= {quo_q[NW-2:0], fits};
    end
  end

  always_comb begin
    wide = 66'(quo_q);
    if (neg_q) begin
      wide = -wide;
    end
    res_o.done = done_q;
    res_o.q    = tls_pkg::sat32(wide);
    if (zero_q) begin
      res_o.q.sat = 1'b1;
      if (npos_q) begin
        res_o.q.val = 32'sh7fffffff;
      end else if (nneg_q) begin
        res_o.q.val = 32'sh80000000;
      end else begin
        res_o.q.val = 32'sd0;
      end
    end
  end

endmodule
